// ----- rtl/core/mcf_pkg.sv -----
package mcf_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int ID_BITS = 16;
    localparam int FILL_BITS = $clog2(HISTORY_DEPTH + 1);

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [FILL_BITS-1:0] fill_t;

    typedef struct packed {
        logic       push;
        id_t        id;
        logic [3:0] len;
    } hist_ctl_t;

    localparam logic [2:0] EV_NOMATCH   = 3'd0;
    localparam logic [2:0] EV_NOISE     = 3'd1;
    localparam logic [2:0] EV_NONE      = 3'd2;
    localparam logic [2:0] EV_MIXHOLD   = 3'd3;
    localparam logic [2:0] EV_TENTATIVE = 3'd4;
    localparam logic [2:0] EV_CONFIRMED = 3'd5;

    localparam logic [2:0] REG_NOISE_FLOOR    = 3'd0;
    localparam logic [2:0] REG_FIRST_ACCEPT   = 3'd1;
    localparam logic [2:0] REG_SWITCH_ACCEPT  = 3'd2;
    localparam logic [2:0] REG_BREAK_NEEDED   = 3'd3;
    localparam logic [2:0] REG_CONFIRM_NEEDED = 3'd4;
    localparam logic [2:0] REG_HISTORY_LENGTH = 3'd5;

    localparam logic [15:0] NOISE_FLOOR_RST    = 16'd6554;
    localparam logic [15:0] FIRST_ACCEPT_RST   = 16'd19661;
    localparam logic [15:0] SWITCH_ACCEPT_RST  = 16'd16384;
    localparam logic [7:0]  BREAK_NEEDED_RST   = 8'd3;
    localparam logic [7:0]  CONFIRM_NEEDED_RST = 8'd2;
    localparam logic [3:0]  HISTORY_LENGTH_RST = 4'd6;

    function automatic logic [7:0] sat_inc(logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    function automatic fill_t eff_len(logic [3:0] hl);
        fill_t r;
        if (hl == 4'd0)
        begin
            r = fill_t'(1);
        end
        else if (int'(hl) > HISTORY_DEPTH)
        begin
            r = fill_t'(HISTORY_DEPTH);
        end
        else
        begin
            r = fill_t'(hl);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mcf_cell.sv -----
module mcf_cell (
    input  logic          clk,
    input  logic          shift,
    input  mcf_pkg::id_t  id_in,
    input  logic          check,
    output mcf_pkg::id_t  id_out,
    output logic          diff
);

    mcf_pkg::id_t id_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            id_reg <= id_in;
        end
    end

    assign id_out = id_reg;
    assign diff   = check && (id_reg != id_in);

endmodule

// ----- rtl/core/mcf_history.sv -----
module mcf_history (
    input  logic               clk,
    input  logic               rst_n,
    input  mcf_pkg::hist_ctl_t ctl,
    output logic               mix
);

    mcf_pkg::fill_t fill_reg;
    mcf_pkg::fill_t fill_next;
    mcf_pkg::fill_t len;
    mcf_pkg::id_t   cell_id [mcf_pkg::HISTORY_DEPTH];
    logic [mcf_pkg::HISTORY_DEPTH-1:0] diff;

    assign len = mcf_pkg::eff_len(ctl.len);

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.push)
        begin
            fill_next = (fill_reg < len) ? fill_reg + 1'b1 : len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // The newest id sits in the first cell; each cell after the first compares itself with its newer neighbour.
    for (genvar i = 0; i < mcf_pkg::HISTORY_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            mcf_cell u_cell (
                .clk    (clk),
                .shift  (ctl.push),
                .id_in  (ctl.id),
                .check  (1'b0),
                .id_out (cell_id[i]),
                .diff   (diff[i])
            );
        end
        else
        begin : g_body
            mcf_cell u_cell (
                .clk    (clk),
                .shift  (ctl.push),
                .id_in  (cell_id[i-1]),
                .check  (fill_reg > mcf_pkg::fill_t'(i)),
                .id_out (cell_id[i]),
                .diff   (diff[i])
            );
        end
    end

    assign mix = |diff;

endmodule

// ----- rtl/core/match_id_confirmation_filter.sv -----
// Classifies each match word from a fingerprint matcher and tracks confirmed,
// pending and tentative identifiers. From acceptance to its result, a word is
// first registered, then an accepted id is shifted into the history chain, and
// then the chain is evaluated and the track state updated, waiting while a held
// result still blocks the output register. A new word is taken once the previous
// result has been loaded into the output register, so the block works on one
// word at a time. Configuration may be written whenever no word is in flight.
module match_id_confirmation_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        matched,
    input  logic [15:0] song_id,
    input  logic [15:0] confidence,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [15:0] echo_id,
    output logic [15:0] echo_confidence
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PUSH   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]  state_reg, state_next;

    logic [15:0] noise_floor_reg, first_accept_reg, switch_accept_reg;
    logic [7:0]  break_needed_reg, confirm_needed_reg;
    logic [3:0]  history_length_reg;

    logic         matched_reg;
    mcf_pkg::id_t id_reg;
    logic [15:0]  conf_reg;

    logic         conf_v_reg, conf_v_next;
    mcf_pkg::id_t conf_id_reg, conf_id_next;
    logic         pend_v_reg, pend_v_next;
    mcf_pkg::id_t pend_id_reg, pend_id_next;
    logic [7:0]   pcnt_reg, pcnt_next;
    logic         tent_v_reg, tent_v_next;
    mcf_pkg::id_t tent_id_reg, tent_id_next;
    logic         brk_v_reg, brk_v_next;
    mcf_pkg::id_t brk_id_reg, brk_id_next;
    logic [7:0]   bcnt_reg, bcnt_next;
    logic         mixing_reg, mixing_next;

    logic         out_valid_reg;
    logic [2:0]   event_reg;
    logic [15:0]  echo_id_reg, echo_conf_reg;

    logic [15:0]  accept;
    logic         is_noise, is_hit, go, mix_det;
    logic [2:0]   ev;
    mcf_pkg::hist_ctl_t hist_ctl;

    logic         fast, mix1, mix2, pnow_v;
    mcf_pkg::id_t pnow_id;
    logic [7:0]   pnow_cnt, p1, p2, need, bnew;

    assign accept   = conf_v_reg ? switch_accept_reg : first_accept_reg;
    assign is_noise = conf_reg < noise_floor_reg;
    assign is_hit   = matched_reg && !is_noise && !(conf_reg < accept);
    assign go       = (state_reg == ST_DECIDE) && (!out_valid_reg || !out_stall);

    assign hist_ctl.push = (state_reg == ST_PUSH) && is_hit;
    assign hist_ctl.id   = id_reg;
    assign hist_ctl.len  = history_length_reg;

    mcf_history u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hist_ctl),
        .mix   (mix_det)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   state_next = (in_valid) ? ST_PUSH : ST_IDLE;
            ST_PUSH:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = go ? ST_IDLE : ST_DECIDE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        conf_v_next  = conf_v_reg;
        conf_id_next = conf_id_reg;
        pend_v_next  = pend_v_reg;
        pend_id_next = pend_id_reg;
        pcnt_next    = pcnt_reg;
        tent_v_next  = tent_v_reg;
        tent_id_next = tent_id_reg;
        brk_v_next   = brk_v_reg;
        brk_id_next  = brk_id_reg;
        bcnt_next    = bcnt_reg;
        mixing_next  = mixing_reg;
        ev           = mcf_pkg::EV_NOMATCH;
        fast         = 1'b0;
        mix1         = 1'b0;
        mix2         = 1'b0;
        pnow_v       = pend_v_reg;
        pnow_id      = pend_id_reg;
        pnow_cnt     = pcnt_reg;
        p1           = 8'd0;
        p2           = 8'd0;
        need         = 8'd1;
        bnew         = 8'd0;

        priority if (!matched_reg || is_noise)
        begin
            pend_v_next  = 1'b0;
            pend_id_next = '0;
            pcnt_next    = 8'd0;
            ev           = matched_reg ? mcf_pkg::EV_NOISE : mcf_pkg::EV_NOMATCH;
        end
        else if (!is_hit)
        begin
            priority if (!conf_v_reg)
            begin
                ev = mcf_pkg::EV_NONE;
            end
            else if (mixing_reg)
            begin
                if (conf_id_reg == id_reg)
                begin
                    mixing_next = 1'b0;
                end
                ev = mcf_pkg::EV_MIXHOLD;
            end
            else if (conf_id_reg == id_reg)
            begin
                ev = mcf_pkg::EV_NONE;
            end
            else if (!tent_v_reg || tent_id_reg == id_reg)
            begin
                tent_v_next  = 1'b1;
                tent_id_next = id_reg;
                brk_v_next   = 1'b0;
                brk_id_next  = '0;
                bcnt_next    = 8'd0;
                ev           = mcf_pkg::EV_TENTATIVE;
            end
            else
            begin
                bnew = (brk_v_reg && brk_id_reg == id_reg) ? mcf_pkg::sat_inc(bcnt_reg) : 8'd1;
                if (bnew >= break_needed_reg)
                begin
                    tent_id_next = id_reg;
                    brk_v_next   = 1'b0;
                    brk_id_next  = '0;
                    bcnt_next    = 8'd0;
                    ev           = mcf_pkg::EV_TENTATIVE;
                end
                else
                begin
                    brk_v_next  = 1'b1;
                    brk_id_next = id_reg;
                    bcnt_next   = bnew;
                    ev          = mcf_pkg::EV_NONE;
                end
            end
        end
        else
        begin
            fast         = tent_v_reg && tent_id_reg == id_reg;
            tent_v_next  = 1'b0;
            tent_id_next = '0;
            brk_v_next   = 1'b0;
            brk_id_next  = '0;
            bcnt_next    = 8'd0;
            if (conf_v_reg && conf_id_reg == id_reg)
            begin
                pend_v_next  = 1'b0;
                pend_id_next = '0;
                pcnt_next    = 8'd0;
                mixing_next  = 1'b0;
                ev           = mcf_pkg::EV_NONE;
            end
            else
            begin
                mix1 = mixing_reg || (conf_v_reg && mix_det);
                mix2 = mix1;
                p1   = (pend_v_reg && pend_id_reg == id_reg) ? mcf_pkg::sat_inc(pcnt_reg) : 8'd1;
                if (mix1 && !fast && p1 < 8'd2)
                begin
                    pend_v_next  = 1'b1;
                    pend_id_next = id_reg;
                    pcnt_next    = p1;
                    mixing_next  = mix1;
                    ev           = mcf_pkg::EV_MIXHOLD;
                end
                else
                begin
                    // A settled mix counts the same hit once more.
                    if (mix1 && !fast)
                    begin
                        mix2     = 1'b0;
                        pnow_v   = 1'b1;
                        pnow_id  = id_reg;
                        pnow_cnt = p1;
                    end
                    need = (fast || !conf_v_reg) ? 8'd1 : confirm_needed_reg;
                    if (fast)
                    begin
                        mix2 = 1'b0;
                    end
                    p2 = (pnow_v && pnow_id == id_reg) ? mcf_pkg::sat_inc(pnow_cnt) : 8'd1;
                    if (p2 < need)
                    begin
                        pend_v_next  = 1'b1;
                        pend_id_next = id_reg;
                        pcnt_next    = p2;
                        mixing_next  = mix2;
                        ev           = mcf_pkg::EV_NONE;
                    end
                    else
                    begin
                        conf_v_next  = 1'b1;
                        conf_id_next = id_reg;
                        pend_v_next  = 1'b0;
                        pend_id_next = '0;
                        pcnt_next    = 8'd0;
                        mixing_next  = 1'b0;
                        ev           = mcf_pkg::EV_CONFIRMED;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            noise_floor_reg    <= mcf_pkg::NOISE_FLOOR_RST;
            first_accept_reg   <= mcf_pkg::FIRST_ACCEPT_RST;
            switch_accept_reg  <= mcf_pkg::SWITCH_ACCEPT_RST;
            break_needed_reg   <= mcf_pkg::BREAK_NEEDED_RST;
            confirm_needed_reg <= mcf_pkg::CONFIRM_NEEDED_RST;
            history_length_reg <= mcf_pkg::HISTORY_LENGTH_RST;
            conf_v_reg         <= 1'b0;
            conf_id_reg        <= '0;
            pend_v_reg         <= 1'b0;
            pend_id_reg        <= '0;
            pcnt_reg           <= 8'd0;
            tent_v_reg         <= 1'b0;
            tent_id_reg        <= '0;
            brk_v_reg          <= 1'b0;
            brk_id_reg         <= '0;
            bcnt_reg           <= 8'd0;
            mixing_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mcf_pkg::REG_NOISE_FLOOR:    noise_floor_reg    <= cfg_data;
                    mcf_pkg::REG_FIRST_ACCEPT:   first_accept_reg   <= cfg_data;
                    mcf_pkg::REG_SWITCH_ACCEPT:  switch_accept_reg  <= cfg_data;
                    mcf_pkg::REG_BREAK_NEEDED:   break_needed_reg   <= cfg_data[7:0];
                    mcf_pkg::REG_CONFIRM_NEEDED: confirm_needed_reg <= cfg_data[7:0];
                    mcf_pkg::REG_HISTORY_LENGTH: history_length_reg <= cfg_data[3:0];
                    default:                     ;
                endcase
            end
            if (go)
            begin
                conf_v_reg  <= conf_v_next;
                conf_id_reg <= conf_id_next;
                pend_v_reg  <= pend_v_next;
                pend_id_reg <= pend_id_next;
                pcnt_reg    <= pcnt_next;
                tent_v_reg  <= tent_v_next;
                tent_id_reg <= tent_id_next;
                brk_v_reg   <= brk_v_next;
                brk_id_reg  <= brk_id_next;
                bcnt_reg    <= bcnt_next;
                mixing_reg  <= mixing_next;
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            matched_reg <= matched;
            id_reg      <= mcf_pkg::id_t'(song_id);
            conf_reg    <= confidence;
        end
        if (go)
        begin
            event_reg     <= ev;
            echo_id_reg   <= 16'(id_reg);
            echo_conf_reg <= conf_reg;
        end
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign event_res       = event_reg;
    assign echo_id         = echo_id_reg;
    assign echo_confidence = echo_conf_reg;

    a_rise_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result word appeared without an evaluation");

    a_accept_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_PUSH))
        else $error("accepted word did not start processing");

    a_confirm_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (go && ev == mcf_pkg::EV_CONFIRMED) |=> (conf_v_reg && conf_id_reg == $past(id_reg)))
        else $error("confirmed event without the track being stored");

    a_mix_needs_track: assert property (@(posedge clk) disable iff (!rst_n)
        (mixing_reg || tent_v_reg) |-> conf_v_reg)
        else $error("mix hold or tentative lock without a confirmed track");

    a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg == (pcnt_reg != 8'd0))
        else $error("pending count disagrees with the pending valid flag");

endmodule
